/* design/ray_cube_face_intersection_defines.svh */
// Assertion macros shared by the ray to cube face intersection design.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef RAY_CUBE_FACE_INTERSECTION_DEFINES_SVH
`define RAY_CUBE_FACE_INTERSECTION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rcf_pkg.sv */
// Package for the ray to cube face intersection design: widths, face codes,
// the queued item type and small helper functions. Depends on nothing.
package rcf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_LEVEL = 8;

    localparam int CW       = 32;
    localparam int IW       = 8;
    localparam int LW       = 4;
    localparam int NAXIS    = 3;
    localparam int NFACE    = 6;
    localparam int PW       = IW + 1 + FRAC_BITS;
    localparam int SPW      = PW + 1;
    localparam int NW       = CW + 2;
    localparam int MW       = NW - 1;
    localparam int DVW      = CW;
    localparam int QW       = MW + FRAC_BITS;
    localparam int QHW      = QW - CW;
    localparam int PRW      = CW + QW;
    localparam int CAP_BIT  = 62;
    localparam int MGW      = CAP_BIT + 1 - FRAC_BITS;
    localparam int PTW      = MGW + 2;
    localparam int RIW      = $clog2(NFACE);

    typedef logic [2:0] face_t;
    typedef logic [1:0] axis_t;

    localparam face_t FACE_LEFT  = 3'd0;
    localparam face_t FACE_RIGHT = 3'd1;
    localparam face_t FACE_UP    = 3'd2;
    localparam face_t FACE_DOWN  = 3'd3;
    localparam face_t FACE_FRONT = 3'd4;
    localparam face_t FACE_BACK  = 3'd5;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    typedef struct packed {
        logic [NAXIS-1:0][CW-1:0]  p;
        logic [NAXIS-1:0]          dneg;
        logic [NAXIS-1:0][DVW-1:0] dmag;
        logic [NAXIS-1:0]          dnz;
        logic [NAXIS-1:0][SPW-1:0] lo;
        logic [NAXIS-1:0][SPW-1:0] hi;
        logic [NFACE-1:0][MW-1:0]  nmag;
        logic [NFACE-1:0]          nneg;
    } item_t;

    function automatic axis_t face_axis(input face_t f);
        axis_t a;
        begin
            case (f)
                FACE_LEFT, FACE_RIGHT: a = AXIS_X;
                FACE_UP, FACE_DOWN:    a = AXIS_Y;
                default:               a = AXIS_Z;
            endcase
            return a;
        end
    endfunction

    function automatic logic face_is_high(input face_t f);
        logic h;
        begin
            case (f)
                FACE_RIGHT, FACE_UP, FACE_FRONT: h = 1'b1;
                default:                         h = 1'b0;
            endcase
            return h;
        end
    endfunction

    function automatic axis_t other_axis(input axis_t a, input logic second);
        axis_t k;
        begin
            if (!second)
            begin
                k = (a == AXIS_X) ? AXIS_Y : AXIS_X;
            end
            else
            begin
                k = (a == AXIS_Z) ? AXIS_Y : AXIS_Z;
            end
            return k;
        end
    endfunction

    function automatic logic [CW-1:0] sat_coord(input logic [PTW-1:0] v);
        logic [CW-1:0] r;
        begin
            if ((&v[PTW-1:CW-1]) || !(|v[PTW-1:CW-1]))
            begin
                r = v[CW-1:0];
            end
            else if (v[PTW-1])
            begin
                r = {1'b1, {(CW-1){1'b0}}};
            end
            else
            begin
                r = {1'b0, {(CW-1){1'b1}}};
            end
            return r;
        end
    endfunction

endpackage

/* design/rcf_front.sv */
// Front stage: takes a ray and a cell, forms the cube bounds, the face plane
// offsets and the direction magnitudes, and hands the item on. Uses rcf_pkg.
module rcf_front import rcf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [CW-1:0] origin_x,
    input  logic signed [CW-1:0] origin_y,
    input  logic signed [CW-1:0] origin_z,
    input  logic signed [CW-1:0] dir_x,
    input  logic signed [CW-1:0] dir_y,
    input  logic signed [CW-1:0] dir_z,
    input  logic [IW-1:0]        cell_x,
    input  logic [IW-1:0]        cell_y,
    input  logic [IW-1:0]        cell_z,
    input  logic [LW-1:0]        level,
    output logic                 q_push,
    input  logic                 q_full,
    output item_t                q_item
);

    logic  hold_reg;
    logic  hold_next;
    item_t item_reg;
    item_t item_next;
    logic  take;

    assign take      = push && !full;
    assign full      = hold_reg && q_full;
    assign hold_next = take || (hold_reg && q_full);
    assign q_push    = hold_reg;
    assign q_item    = item_reg;

    always_comb
    begin
        logic [LW-1:0]              lvl;
        logic [NAXIS-1:0][CW-1:0]   p;
        logic [NAXIS-1:0][CW-1:0]   d;
        logic [NAXIS-1:0][IW-1:0]   idx;
        logic [PW-1:0]              lw;
        logic [PW-1:0]              hw;
        logic [SPW-1:0]             plane;
        logic [NW-1:0]              num;
        axis_t                      a;
        lvl = ({1'b0, level} > (LW+1)'(MAX_LEVEL)) ? LW'(MAX_LEVEL) : level;
        p   = {origin_z, origin_y, origin_x};
        d   = {dir_z, dir_y, dir_x};
        idx = {cell_z, cell_y, cell_x};
        item_next = '0;
        for (int i = 0; i < NAXIS; i++)
        begin
            lw = {1'b0, idx[i], {FRAC_BITS{1'b0}}} >> lvl;
            hw = {(IW+1)'(idx[i]) + (IW+1)'(1), {FRAC_BITS{1'b0}}} >> lvl;
            if (axis_t'(i) == AXIS_Z)
            begin
                item_next.lo[i] = -{1'b0, hw};
                item_next.hi[i] = -{1'b0, lw};
            end
            else
            begin
                item_next.lo[i] = {1'b0, lw};
                item_next.hi[i] = {1'b0, hw};
            end
            item_next.p[i]    = p[i];
            item_next.dneg[i] = d[i][CW-1];
            item_next.dmag[i] = d[i][CW-1] ? -d[i] : d[i];
            item_next.dnz[i]  = |d[i];
        end
        for (int f = 0; f < NFACE; f++)
        begin
            a     = face_axis(face_t'(f));
            plane = face_is_high(face_t'(f)) ? item_next.hi[a] : item_next.lo[a];
            num   = {{(NW-SPW){plane[SPW-1]}}, plane} - {{(NW-CW){p[a][CW-1]}}, p[a]};
            item_next.nneg[f] = num[NW-1];
            item_next.nmag[f] = num[NW-1] ? MW'(-num) : num[MW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* design/rcf_queue.sv */
// Two-entry queue between the front and back stages.
// Uses the item type of rcf_pkg.
module rcf_queue import rcf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t item_in,
    input  logic  pop,
    output logic  empty,
    output item_t item_out
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    item_t           ent_reg [DEPTH];
    logic [AW-1:0]   wr_reg;
    logic [AW-1:0]   wr_next;
    logic [AW-1:0]   rd_reg;
    logic [AW-1:0]   rd_next;
    logic [AW:0]     cnt_reg;
    logic [AW:0]     cnt_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (cnt_reg == (AW+1)'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign item_out = ent_reg[rd_reg];
    assign wr_next  = do_push ? wr_reg + AW'(1) : wr_reg;
    assign rd_next  = do_pop ? rd_reg + AW'(1) : rd_reg;
    assign cnt_next = cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_reg] <= item_in;
        end
    end

endmodule

/* design/rcf_div.sv */
// Restoring divider, one quotient bit per cycle, for the ray parameter.
// Uses widths from rcf_pkg.
module rcf_div import rcf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [QW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    output logic           done,
    output logic [QW-1:0]  quotient
);

    localparam int CNTW = $clog2(QW + 1);

    logic            busy_reg;
    logic            busy_next;
    logic            done_reg;
    logic            done_next;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic [DVW-1:0]  rem_reg;
    logic [DVW-1:0]  rem_next;
    logic [QW-1:0]   quo_reg;
    logic [QW-1:0]   quo_next;
    logic [DVW-1:0]  dvs_reg;
    logic [DVW:0]    shifted;
    logic            fits;

    assign shifted  = {rem_reg, quo_reg[QW-1]};
    assign fits     = (shifted >= {1'b0, dvs_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(QW);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DVW'(shifted - {1'b0, dvs_reg}) : shifted[DVW-1:0];
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

endmodule

/* design/rcf_back.sv */
// Back stage: walks the six faces of a queued item with a shared divider and
// multiplier, and buffers its results for the output side. Uses rcf_pkg, rcf_div.
module rcf_back import rcf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  item_t                item,
    output logic                 item_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic                 face_valid,
    output logic [2:0]           face_code,
    output logic signed [CW-1:0] hit_x,
    output logic signed [CW-1:0] hit_y,
    output logic signed [CW-1:0] hit_z,
    output logic                 cube_hit,
    output logic                 last_result
);

`include "ray_cube_face_intersection_defines.svh"

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FACE   = 8'b0000_0010,
        S_DIV    = 8'b0000_0100,
        S_MUL    = 8'b0000_1000,
        S_ACC    = 8'b0001_0000,
        S_PT     = 8'b0010_0000,
        S_COMMIT = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } state_t;

    localparam logic [PRW-1:0] PROD_CAP = PRW'(1) << CAP_BIT;

    state_t          st_reg, st_next;
    face_t           face_reg, face_next;
    logic            oth_reg, oth_next;
    logic            half_reg, half_next;
    logic            inside_reg, inside_next;
    logic            cube_reg, cube_next;
    logic [RIW-1:0]  n_reg, n_next;
    logic            pub_reg, pub_next;
    logic            pub_cube_reg, pub_cube_next;
    logic [RIW-1:0]  pub_n_reg, pub_n_next;
    logic [RIW-1:0]  rd_reg, rd_next;

    logic [QW-1:0]              quo_reg;
    logic [2*CW-1:0]            prod_reg;
    logic [PRW-1:0]             acc_reg;
    logic [NAXIS-1:0][CW-1:0]   pt_reg;

    logic            res_fv_reg   [NFACE];
    face_t           res_code_reg [NFACE];
    logic [CW-1:0]   res_x_reg    [NFACE];
    logic [CW-1:0]   res_y_reg    [NFACE];
    logic [CW-1:0]   res_z_reg    [NFACE];

    axis_t           axis;
    axis_t           k;
    logic [SPW-1:0]  plane;
    logic [CW-1:0]   chunk;
    logic [CAP_BIT:0] capped;
    logic [MGW-1:0]  mag_off;
    logic            neg;
    logic [PTW-1:0]  po_ext;
    logic [PTW-1:0]  pt_calc;
    logic [PTW-1:0]  lo_ext;
    logic [PTW-1:0]  hi_ext;
    logic            in_bounds;
    logic            report;
    logic            div_start;
    logic            div_done;
    logic [QW-1:0]   div_q;
    logic            res_we;
    logic            res_fv_w;
    logic            out_take;
    logic            out_last;

    assign axis      = face_axis(face_reg);
    assign k         = other_axis(axis, oth_reg);
    assign plane     = face_is_high(face_reg) ? item.hi[axis] : item.lo[axis];
    assign chunk     = half_reg ? CW'(quo_reg[QW-1:CW]) : quo_reg[CW-1:0];
    assign capped    = (acc_reg > PROD_CAP) ? PROD_CAP[CAP_BIT:0] : acc_reg[CAP_BIT:0];
    assign mag_off   = capped[CAP_BIT:FRAC_BITS];
    assign neg       = item.nneg[face_reg] ^ item.dneg[axis] ^ item.dneg[k];
    assign po_ext    = {{(PTW-CW){item.p[k][CW-1]}}, item.p[k]};
    assign pt_calc   = neg ? po_ext - {2'b00, mag_off} : po_ext + {2'b00, mag_off};
    assign lo_ext    = {{(PTW-SPW){item.lo[k][SPW-1]}}, item.lo[k]};
    assign hi_ext    = {{(PTW-SPW){item.hi[k][SPW-1]}}, item.hi[k]};
    assign in_bounds = !($signed(pt_calc) < $signed(lo_ext))
                       && !($signed(pt_calc) > $signed(hi_ext));
    assign report    = inside_reg
                       && ((item.nmag[face_reg] == '0) || (item.nneg[face_reg] == item.dneg[axis]));
    assign div_start = (st_reg == S_FACE) && item.dnz[axis];

    rcf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({item.nmag[face_reg], {FRAC_BITS{1'b0}}}),
        .divisor  (item.dmag[axis]),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_take = pop && pub_reg;
    assign out_last = (rd_reg == pub_n_reg - RIW'(1));

    always_comb
    begin
        st_next       = st_reg;
        face_next     = face_reg;
        oth_next      = oth_reg;
        half_next     = half_reg;
        inside_next   = inside_reg;
        cube_next     = cube_reg;
        n_next        = n_reg;
        pub_next      = pub_reg;
        pub_cube_next = pub_cube_reg;
        pub_n_next    = pub_n_reg;
        rd_next       = rd_reg;
        res_we        = 1'b0;
        res_fv_w      = 1'b0;
        item_pop      = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    face_next = FACE_LEFT;
                    n_next    = '0;
                    cube_next = 1'b0;
                    st_next   = S_FACE;
                end
            end
            S_FACE:
            begin
                if (item.dnz[axis])
                begin
                    st_next = S_DIV;
                end
                else if (face_reg == FACE_BACK)
                begin
                    st_next = S_FIN;
                end
                else
                begin
                    face_next = face_reg + face_t'(1);
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    oth_next    = 1'b0;
                    half_next   = 1'b0;
                    inside_next = 1'b1;
                    st_next     = S_MUL;
                end
            end
            S_MUL:
            begin
                st_next = S_ACC;
            end
            S_ACC:
            begin
                if (!half_reg)
                begin
                    half_next = 1'b1;
                    st_next   = S_MUL;
                end
                else
                begin
                    st_next = S_PT;
                end
            end
            S_PT:
            begin
                inside_next = inside_reg && in_bounds;
                if (!oth_reg)
                begin
                    oth_next  = 1'b1;
                    half_next = 1'b0;
                    st_next   = S_MUL;
                end
                else
                begin
                    st_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (!report || !pub_reg)
                begin
                    if (inside_reg)
                    begin
                        cube_next = 1'b1;
                    end
                    if (report)
                    begin
                        res_we   = 1'b1;
                        res_fv_w = 1'b1;
                        n_next   = n_reg + RIW'(1);
                    end
                    if (face_reg == FACE_BACK)
                    begin
                        st_next = S_FIN;
                    end
                    else
                    begin
                        face_next = face_reg + face_t'(1);
                        st_next   = S_FACE;
                    end
                end
            end
            S_FIN:
            begin
                if (!pub_reg)
                begin
                    res_we        = (n_reg == '0);
                    pub_next      = 1'b1;
                    pub_cube_next = cube_reg;
                    pub_n_next    = (n_reg == '0) ? RIW'(1) : n_reg;
                    rd_next       = '0;
                    item_pop      = 1'b1;
                    st_next       = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
        if (out_take)
        begin
            if (out_last)
            begin
                pub_next = 1'b0;
                rd_next  = '0;
            end
            else
            begin
                rd_next = rd_reg + RIW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_IDLE;
            face_reg     <= FACE_LEFT;
            oth_reg      <= 1'b0;
            half_reg     <= 1'b0;
            inside_reg   <= 1'b0;
            cube_reg     <= 1'b0;
            n_reg        <= '0;
            pub_reg      <= 1'b0;
            pub_cube_reg <= 1'b0;
            pub_n_reg    <= '0;
            rd_reg       <= '0;
        end
        else
        begin
            st_reg       <= st_next;
            face_reg     <= face_next;
            oth_reg      <= oth_next;
            half_reg     <= half_next;
            inside_reg   <= inside_next;
            cube_reg     <= cube_next;
            n_reg        <= n_next;
            pub_reg      <= pub_next;
            pub_cube_reg <= pub_cube_next;
            pub_n_reg    <= pub_n_next;
            rd_reg       <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((st_reg == S_DIV) && div_done)
        begin
            quo_reg      <= div_q;
            pt_reg[axis] <= {{(CW-SPW){plane[SPW-1]}}, plane};
        end
        if (st_reg == S_MUL)
        begin
            prod_reg <= item.dmag[k] * chunk;
        end
        if (st_reg == S_ACC)
        begin
            acc_reg <= half_reg ? acc_reg + {prod_reg[QW-1:0], {CW{1'b0}}}
                                : {{QHW{1'b0}}, prod_reg};
        end
        if (st_reg == S_PT)
        begin
            pt_reg[k] <= sat_coord(pt_calc);
        end
        if (res_we)
        begin
            res_fv_reg[n_reg]   <= res_fv_w;
            res_code_reg[n_reg] <= res_fv_w ? face_reg : FACE_LEFT;
            res_x_reg[n_reg]    <= res_fv_w ? pt_reg[AXIS_X] : '0;
            res_y_reg[n_reg]    <= res_fv_w ? pt_reg[AXIS_Y] : '0;
            res_z_reg[n_reg]    <= res_fv_w ? pt_reg[AXIS_Z] : '0;
        end
    end

    assign empty       = !pub_reg;
    assign face_valid  = res_fv_reg[rd_reg];
    assign face_code   = res_code_reg[rd_reg];
    assign hit_x       = res_x_reg[rd_reg];
    assign hit_y       = res_y_reg[rd_reg];
    assign hit_z       = res_z_reg[rd_reg];
    assign cube_hit    = pub_cube_reg;
    assign last_result = out_last;

    `RCF_ASSERT_IMPL(a_write_unpublished, res_we, !pub_reg, "result written while buffer published")
    `RCF_ASSERT_IMPL(a_read_in_range, pub_reg, rd_reg < pub_n_reg, "result read past count")
    `RCF_ASSERT_IMPL(a_pop_has_item, item_pop, item_valid, "item released with none queued")
    `RCF_ASSERT_NEXT(a_last_clears, out_take && out_last, !pub_reg, "buffer still published")

endmodule

/* design/ray_cube_face_intersection.sv */
// From an input transfer to the first result, an item passes the front stage register,
// the queue, and per face the 49-step serial divider, four multiply steps, set-up,
// bound and commit, and the results are then published. A face whose axis has a zero
// direction skips the divider and multiply. Items wait in the queue while the back stage
// works; up to 6 results per item, one transfer per cycle, stalls while unread.
// Reset: rst_n asynchronous active low; clears control state, queue and result buffer empty.
module ray_cube_face_intersection import rcf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [CW-1:0] origin_x,
    input  logic signed [CW-1:0] origin_y,
    input  logic signed [CW-1:0] origin_z,
    input  logic signed [CW-1:0] dir_x,
    input  logic signed [CW-1:0] dir_y,
    input  logic signed [CW-1:0] dir_z,
    input  logic [IW-1:0]        cell_x,
    input  logic [IW-1:0]        cell_y,
    input  logic [IW-1:0]        cell_z,
    input  logic [LW-1:0]        level,
    output logic                 empty,
    input  logic                 pop,
    output logic                 face_valid,
    output logic [2:0]           face_code,
    output logic signed [CW-1:0] hit_x,
    output logic signed [CW-1:0] hit_y,
    output logic signed [CW-1:0] hit_z,
    output logic                 cube_hit,
    output logic                 last_result
);

    logic  q_push;
    logic  q_full;
    item_t q_in;
    logic  q_pop;
    logic  q_empty;
    item_t q_out;

    rcf_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .origin_x (origin_x),
        .origin_y (origin_y),
        .origin_z (origin_z),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z),
        .cell_x   (cell_x),
        .cell_y   (cell_y),
        .cell_z   (cell_z),
        .level    (level),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_item   (q_in)
    );

    rcf_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .full     (q_full),
        .item_in  (q_in),
        .pop      (q_pop),
        .empty    (q_empty),
        .item_out (q_out)
    );

    rcf_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (!q_empty),
        .item        (q_out),
        .item_pop    (q_pop),
        .empty       (empty),
        .pop         (pop),
        .face_valid  (face_valid),
        .face_code   (face_code),
        .hit_x       (hit_x),
        .hit_y       (hit_y),
        .hit_z       (hit_z),
        .cube_hit    (cube_hit),
        .last_result (last_result)
    );

endmodule
